@@ sv/tcmr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcmr_pkg: shared types and constants of the cost matrix reduction engine
// Operation codes, sequencer states and the fixed port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tcmr_pkg;

   localparam int OP_W       = 3;
   localparam int PORT_IDX_W = 5;
   localparam int PORT_COST_W = 17;
   localparam int SIZE_W     = 6;
   localparam int SUM_W      = 22;
   localparam int PEN_W      = 17;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
   localparam logic [SUM_W-1:0]  SUM_MAX    = 22'h3FFFFF;
   localparam logic [PEN_W-1:0]  PEN_MAX    = 17'h1FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 3'd0,
      OP_FORBID = 3'd1,
      OP_DELETE = 3'd2,
      OP_REDUCE = 3'd3,
      OP_EVAL   = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINE,
      ST_MIN,
      ST_MIN_END,
      ST_STAT,
      ST_SUB,
      ST_SUB_END,
      ST_OUT
   } state_type;

   // Pass over the matrix: reduce rows, reduce columns, column statistics,
   // then row scan for zero penalties.
   typedef enum logic [1:0] {
      PH_RROW,
      PH_RCOL,
      PH_ECOL,
      PH_EROW
   } phase_type;

   typedef struct packed {
      logic clear;
      logic feed;
   } min_ctl_type;

endpackage

`default_nettype wire

@@ sv/tcmr_ram.sv @@
// ----------------------------------------------------------------------------
// tcmr_ram: generic single write port, single read port RAM
// Read data is registered: data for an address appears in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcmr_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/tcmr_min_track.sv @@
// ----------------------------------------------------------------------------
// tcmr_min_track: running least and second least value of one line
// Keeps the smallest value with its index and the least of the others, so
// that the minimum with any one element left out can be read back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcmr_min_track
   import tcmr_pkg::*;
#(
   parameter int COST_BITS = 16,
   parameter int IDX_W     = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire min_ctl_type          ctl,
   input  wire logic [COST_BITS-1:0] value,
   input  wire logic [IDX_W-1:0]     index,
   output logic                      have1,
   output logic      [COST_BITS-1:0] min1,
   output logic      [IDX_W-1:0]     idx1,
   output logic                      have2,
   output logic      [COST_BITS-1:0] min2
);

   logic                 have1_ff, have1_in, have2_ff, have2_in;
   logic [COST_BITS-1:0] min1_ff, min1_in, min2_ff, min2_in;
   logic [IDX_W-1:0]     idx1_ff, idx1_in;

   always_comb begin
      have1_in = have1_ff;
      have2_in = have2_ff;
      min1_in  = min1_ff;
      min2_in  = min2_ff;
      idx1_in  = idx1_ff;
      if (ctl.clear) begin
         have1_in = 1'b0;
         have2_in = 1'b0;
      end else if (ctl.feed) begin
         if (!have1_ff) begin
            have1_in = 1'b1;
            min1_in  = value;
            idx1_in  = index;
         end else if (value < min1_ff) begin
            // demote the old least to second place
            have2_in = 1'b1;
            min2_in  = min1_ff;
            min1_in  = value;
            idx1_in  = index;
         end else if (!have2_ff || value < min2_ff) begin
            have2_in = 1'b1;
            min2_in  = value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have1_ff <= 1'b0;
         have2_ff <= 1'b0;
      end else begin
         have1_ff <= have1_in;
         have2_ff <= have2_in;
      end
   end

   always_ff @(posedge clock) begin
      min1_ff <= min1_in;
      min2_ff <= min2_in;
      idx1_ff <= idx1_in;
   end

   assign have1 = have1_ff;
   assign have2 = have2_ff;
   assign min1  = min1_ff;
   assign min2  = min2_ff;
   assign idx1  = idx1_ff;

endmodule

`default_nettype wire

@@ sv/tsp_cost_matrix_reduction_engine.sv @@
// ----------------------------------------------------------------------------
// tsp_cost_matrix_reduction_engine: branch-and-bound cost matrix reducer
// Holds the cost matrix, applies cell loads, forbids and row/column deletes,
// and runs matrix reduction and zero penalty evaluation over it.
// ----------------------------------------------------------------------------
//  channel | direction | ports               | carries
//  csr     | in        | csr_valid/ready     | size_in_use
//  req     | in        | req_valid/ready     | opcode, row, col, cost
//  rsp     | out       | rsp_valid/ready     | one result per reduce/evaluate
//
// Reduce and evaluate are paced by the single read port of the cost RAM:
// each cell of an active line is read for the line minimum and, but in the
// column statistics pass, again to subtract or score. The removed flags and
// size reset at once; the cost RAM is not cleared. req_ready is low while
// a reduce or evaluate runs; a result held in the output register waits
// for rsp_ready without blocking new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_cost_matrix_reduction_engine
   import tcmr_pkg::*;
#(
   parameter int MAX_CITIES = 32,
   parameter int COST_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [SIZE_W-1:0]      csr_size_in_use,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OP_W-1:0]        req_opcode,
   input  wire logic [PORT_IDX_W-1:0]  req_row,
   input  wire logic [PORT_IDX_W-1:0]  req_col,
   input  wire logic signed [PORT_COST_W-1:0] req_cost,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_result_kind,
   output logic      [SUM_W-1:0]       rsp_reduction_sum,
   output logic                        rsp_all_forbidden,
   output logic      [PORT_IDX_W-1:0]  rsp_branch_row,
   output logic      [PORT_IDX_W-1:0]  rsp_branch_col,
   output logic      [PEN_W-1:0]       rsp_branch_penalty,
   output logic                        rsp_zero_found
);

   localparam int IDX_W  = $clog2(MAX_CITIES);
   localparam int N_W    = $clog2(MAX_CITIES + 1);
   localparam int SW     = COST_BITS + 1;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int STAT_W = 2 * COST_BITS + IDX_W + 2;
   localparam int P_W    = COST_BITS + 1;
   localparam logic [31:0] CAP32 = (32'd1 << COST_BITS) - 32'd1;

   // control registers
   state_type             state_ff, state_in;
   phase_type             ph_ff, ph_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [MAX_CITIES-1:0] row_rm_ff, row_rm_in, col_rm_ff, col_rm_in;
   logic                  p_vld_ff, p_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [N_W-1:0]        outer_ff, outer_in, inner_ff, inner_in;
   logic                  p_sub_ff, p_sub_in;
   logic [IDX_W-1:0]      p_idx_ff, p_idx_in;
   logic [ADDR_W-1:0]     p_addr_ff, p_addr_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  allf_ff, allf_in, found_ff, found_in;
   logic [P_W-1:0]        best_ff, best_in;
   logic [IDX_W-1:0]      br_ff, br_in, bc_ff, bc_in;
   logic                  rsp_kind_ff, rsp_kind_in, rsp_allf_ff, rsp_allf_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [SUM_W-1:0]      rsp_sum_ff, rsp_sum_in;
   logic [PORT_IDX_W-1:0] rsp_br_ff, rsp_br_in, rsp_bc_ff, rsp_bc_in;
   logic [PEN_W-1:0]      rsp_pen_ff, rsp_pen_in;

   // datapath nets
   logic [N_W-1:0]        n_cur, n_last;
   logic                  in_range, row_mode, line_rm, p_act;
   logic [IDX_W-1:0]      ri, ci, out_idx;
   logic [SW-1:0]         ld_val;
   logic [31:0]           raw_ext;
   logic                  wr_en, st_wr;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [SW-1:0]         wr_data, rd_data;
   logic [STAT_W-1:0]     st_wdata, st_rdata;
   logic                  v_neg, v_pos, v_zero;
   logic [COST_BITS-1:0]  v_mag, m_line, rowex, colex;
   min_ctl_type           t_ctl;
   logic                  t_have1, t_have2;
   logic [COST_BITS-1:0]  t_min1, t_min2;
   logic [IDX_W-1:0]      t_idx1;
   logic                  s_have1, s_have2;
   logic [COST_BITS-1:0]  s_min1, s_min2;
   logic [IDX_W-1:0]      s_idx1;
   logic [P_W-1:0]        pen;
   logic [32:0]           sum_ext;

   tcmr_ram #(
      .WIDTH (SW),
      .DEPTH (1 << ADDR_W)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tcmr_ram #(
      .WIDTH (STAT_W),
      .DEPTH (1 << IDX_W)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (out_idx),
      .wr_data (st_wdata),
      .rd_addr (inner_ff[IDX_W-1:0]),
      .rd_data (st_rdata)
   );

   tcmr_min_track #(
      .COST_BITS (COST_BITS),
      .IDX_W     (IDX_W)
   ) u_min_track (
      .clock (clock),
      .reset (reset),
      .ctl   (t_ctl),
      .value (v_mag),
      .index (p_idx_ff),
      .have1 (t_have1),
      .min1  (t_min1),
      .idx1  (t_idx1),
      .have2 (t_have2),
      .min2  (t_min2)
   );

   // cities in use, clamped to 1..MAX_CITIES
   always_comb begin
      if (size_ff == '0) begin
         n_cur = N_W'(1);
      end else if (32'(size_ff) > 32'(MAX_CITIES)) begin
         n_cur = N_W'(MAX_CITIES);
      end else begin
         n_cur = N_W'(size_ff);
      end
   end

   assign n_last   = n_cur - N_W'(1);
   assign in_range = (32'(req_row) < 32'(n_cur)) && (32'(req_col) < 32'(n_cur));
   assign ri       = IDX_W'(req_row);
   assign ci       = IDX_W'(req_col);
   assign out_idx  = outer_ff[IDX_W-1:0];

   // negative costs are forbidden, large costs saturate
   assign raw_ext = {16'b0, req_cost[15:0]};
   always_comb begin
      if (req_cost[16]) begin
         ld_val = {SW{1'b1}};
      end else if (raw_ext > CAP32) begin
         ld_val = {1'b0, CAP32[COST_BITS-1:0]};
      end else begin
         ld_val = {1'b0, COST_BITS'(raw_ext)};
      end
   end

   assign row_mode = (ph_ff == PH_RROW) || (ph_ff == PH_EROW);
   assign line_rm  = row_mode ? row_rm_ff[out_idx] : col_rm_ff[out_idx];
   assign p_act    = row_mode ? !col_rm_ff[p_idx_ff] : !row_rm_ff[p_idx_ff];
   assign rd_addr  = row_mode ? {out_idx, inner_ff[IDX_W-1:0]}
                              : {inner_ff[IDX_W-1:0], out_idx};

   assign v_neg  = rd_data[SW-1];
   assign v_mag  = rd_data[COST_BITS-1:0];
   assign v_pos  = !v_neg && (v_mag != '0);
   assign v_zero = !v_neg && (v_mag == '0);

   assign m_line = t_have1 ? t_min1 : '0;
   assign rowex  = (t_have1 && t_idx1 == p_idx_ff) ? (t_have2 ? t_min2 : '0) : m_line;

   assign st_wdata = {t_have1, t_min1, t_idx1, t_have2, t_min2};
   assign s_min2   = st_rdata[COST_BITS-1:0];
   assign s_have2  = st_rdata[COST_BITS];
   assign s_idx1   = st_rdata[COST_BITS+IDX_W:COST_BITS+1];
   assign s_min1   = st_rdata[2*COST_BITS+IDX_W:COST_BITS+IDX_W+1];
   assign s_have1  = st_rdata[STAT_W-1];
   assign colex    = (s_have1 && s_idx1 == out_idx) ? (s_have2 ? s_min2 : '0)
                                                   : (s_have1 ? s_min1 : '0);
   assign pen      = P_W'(rowex) + P_W'(colex);
   assign sum_ext  = 33'(sum_ff) + 33'(m_line);

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      size_in      = size_ff;
      row_rm_in    = row_rm_ff;
      col_rm_in    = col_rm_ff;
      outer_in     = outer_ff;
      inner_in     = inner_ff;
      p_vld_in     = 1'b0;
      p_sub_in     = p_sub_ff;
      p_idx_in     = inner_ff[IDX_W-1:0];
      p_addr_in    = rd_addr;
      sum_in       = sum_ff;
      allf_in      = allf_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      br_in        = br_ff;
      bc_in        = bc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_allf_in  = rsp_allf_ff;
      rsp_br_in    = rsp_br_ff;
      rsp_bc_in    = rsp_bc_ff;
      rsp_pen_in   = rsp_pen_ff;
      rsp_found_in = rsp_found_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = p_addr_ff;
      wr_data      = {1'b0, v_mag - m_line};
      st_wr        = 1'b0;
      t_ctl.clear  = 1'b0;
      t_ctl.feed   = p_vld_ff && !p_sub_ff && p_act && !v_neg;

      if (csr_valid) begin
         size_in = csr_size_in_use;
      end

      // back end of the read pipe: subtract, check or score the cell
      if (p_vld_ff && p_sub_ff && p_act) begin
         if (ph_ff == PH_RROW || ph_ff == PH_RCOL) begin
            wr_en = v_pos;
            if (ph_ff == PH_RCOL && !v_neg) begin
               allf_in = 1'b0;
            end
         end else if (ph_ff == PH_EROW && v_zero) begin
            if (!found_ff || pen > best_ff) begin
               found_in = 1'b1;
               best_in  = pen;
               br_in    = out_idx;
               bc_in    = p_idx_ff;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_opcode)
                  OP_LOAD: begin
                     if (in_range) begin
                        wr_en         = 1'b1;
                        wr_addr       = {ri, ci};
                        wr_data       = ld_val;
                        row_rm_in[ri] = 1'b0;
                        col_rm_in[ci] = 1'b0;
                     end
                  end
                  OP_FORBID: begin
                     if (in_range && !row_rm_ff[ri] && !col_rm_ff[ci]) begin
                        wr_en   = 1'b1;
                        wr_addr = {ri, ci};
                        wr_data = {SW{1'b1}};
                     end
                  end
                  OP_DELETE: begin
                     if (in_range) begin
                        // forbid the reverse edge while it is still active
                        if (!row_rm_ff[ci] && !col_rm_ff[ri]) begin
                           wr_en   = 1'b1;
                           wr_addr = {ci, ri};
                           wr_data = {SW{1'b1}};
                        end
                        row_rm_in[ri] = 1'b1;
                        col_rm_in[ci] = 1'b1;
                     end
                  end
                  OP_REDUCE: begin
                     ph_in    = PH_RROW;
                     outer_in = '0;
                     sum_in   = '0;
                     allf_in  = 1'b1;
                     state_in = ST_LINE;
                  end
                  OP_EVAL: begin
                     ph_in    = PH_ECOL;
                     outer_in = '0;
                     found_in = 1'b0;
                     best_in  = '0;
                     br_in    = '0;
                     bc_in    = '0;
                     state_in = ST_LINE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LINE: begin
            if (outer_ff == n_cur) begin
               outer_in = '0;
               case (ph_ff)
                  PH_RROW: ph_in    = PH_RCOL;
                  PH_ECOL: ph_in    = PH_EROW;
                  default: state_in = ST_OUT;
               endcase
            end else if (line_rm) begin
               outer_in = outer_ff + N_W'(1);
            end else begin
               t_ctl.clear = 1'b1;
               inner_in    = '0;
               state_in    = ST_MIN;
            end
         end
         ST_MIN: begin
            p_vld_in = 1'b1;
            p_sub_in = 1'b0;
            if (inner_ff == n_last) begin
               state_in = ST_MIN_END;
            end else begin
               inner_in = inner_ff + N_W'(1);
            end
         end
         ST_MIN_END: begin
            inner_in = '0;
            state_in = (ph_ff == PH_ECOL) ? ST_STAT : ST_SUB;
         end
         ST_STAT: begin
            st_wr    = 1'b1;
            outer_in = outer_ff + N_W'(1);
            state_in = ST_LINE;
         end
         ST_SUB: begin
            p_vld_in = 1'b1;
            p_sub_in = 1'b1;
            if (inner_ff == n_last) begin
               state_in = ST_SUB_END;
            end else begin
               inner_in = inner_ff + N_W'(1);
            end
         end
         ST_SUB_END: begin
            if (ph_ff == PH_RROW || ph_ff == PH_RCOL) begin
               sum_in = (sum_ext > 33'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
            end
            outer_in = outer_ff + N_W'(1);
            state_in = ST_LINE;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (ph_ff == PH_EROW) begin
                  rsp_kind_in  = 1'b1;
                  rsp_sum_in   = '0;
                  rsp_allf_in  = 1'b0;
                  rsp_br_in    = PORT_IDX_W'(br_ff);
                  rsp_bc_in    = PORT_IDX_W'(bc_ff);
                  rsp_pen_in   = (33'(best_ff) > 33'(PEN_MAX)) ? PEN_MAX
                                                              : PEN_W'(best_ff);
                  rsp_found_in = found_ff;
               end else begin
                  rsp_kind_in  = 1'b0;
                  rsp_sum_in   = sum_ff;
                  rsp_allf_in  = allf_ff;
                  rsp_br_in    = '0;
                  rsp_bc_in    = '0;
                  rsp_pen_in   = '0;
                  rsp_found_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= PH_RROW;
         size_ff      <= SIZE_RESET;
         row_rm_ff    <= '0;
         col_rm_ff    <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         size_ff      <= size_in;
         row_rm_ff    <= row_rm_in;
         col_rm_ff    <= col_rm_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_ff     <= outer_in;
      inner_ff     <= inner_in;
      p_sub_ff     <= p_sub_in;
      p_idx_ff     <= p_idx_in;
      p_addr_ff    <= p_addr_in;
      sum_ff       <= sum_in;
      allf_ff      <= allf_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      br_ff        <= br_in;
      bc_ff        <= bc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_allf_ff  <= rsp_allf_in;
      rsp_br_ff    <= rsp_br_in;
      rsp_bc_ff    <= rsp_bc_in;
      rsp_pen_ff   <= rsp_pen_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_reduction_sum  = rsp_sum_ff;
   assign rsp_all_forbidden  = rsp_allf_ff;
   assign rsp_branch_row     = rsp_br_ff;
   assign rsp_branch_col     = rsp_bc_ff;
   assign rsp_branch_penalty = rsp_pen_ff;
   assign rsp_zero_found     = rsp_found_ff;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cost matrix reduction engine
// Drives cell loads, forbids, deletes, reduces and zero evaluations over
// several matrix sizes. A local matrix model predicts every reduction and
// branching result, and each response is checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import tcmr_pkg::*;

   localparam int NCITY     = 32;
   localparam int CYCLE_CAP = 2000000;
   localparam int HOLD_LEN  = 3000;

   typedef struct {
      logic [OP_W-1:0]        op;
      logic [PORT_IDX_W-1:0]  row;
      logic [PORT_IDX_W-1:0]  col;
      logic [PORT_COST_W-1:0] cost;
   } cell_req_type;

   typedef struct {
      logic             kind;
      logic [SUM_W-1:0] sum;
      logic             all_forb;
      logic [4:0]       brow;
      logic [4:0]       bcol;
      logic [PEN_W-1:0] pen;
      logic             zfound;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SIZE_W-1:0] csr_size_in_use = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_opcode = '0;
   logic [PORT_IDX_W-1:0] req_row = '0;
   logic [PORT_IDX_W-1:0] req_col = '0;
   logic signed [PORT_COST_W-1:0] req_cost = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_result_kind;
   logic [SUM_W-1:0] rsp_reduction_sum;
   logic rsp_all_forbidden;
   logic [PORT_IDX_W-1:0] rsp_branch_row;
   logic [PORT_IDX_W-1:0] rsp_branch_col;
   logic [PEN_W-1:0] rsp_branch_penalty;
   logic rsp_zero_found;

   tsp_cost_matrix_reduction_engine i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_size_in_use(csr_size_in_use),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_row(req_row), .req_col(req_col), .req_cost(req_cost),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_kind(rsp_result_kind),
      .rsp_reduction_sum(rsp_reduction_sum), .rsp_all_forbidden(rsp_all_forbidden),
      .rsp_branch_row(rsp_branch_row), .rsp_branch_col(rsp_branch_col),
      .rsp_branch_penalty(rsp_branch_penalty), .rsp_zero_found(rsp_zero_found)
   );

   always #10 clock = ~clock;

   cell_req_type pending_reqs[$];
   outcome_type  expected_outcomes[$];
   int        mismatches = 0;
   int        cycles = 0;
   logic      req_taken = 1'b0;
   bit        calm = 1'b0;
   bit        stall_now = 1'b0;
   bit        stall_started = 1'b0;
   int        hold_left = 0;

   // matrix model
   int mat[NCITY][NCITY];
   bit row_gone[NCITY];
   bit col_gone[NCITY];
   int size_reg = SIZE_RESET;

   // stimulus side bookkeeping: cells loaded so far, size in force
   bit loaded[NCITY][NCITY];
   int gen_n = NCITY;

   function automatic int cities_in_use();
      int n;
      n = size_reg;
      if (n == 0) n = 1;
      if (n > NCITY) n = NCITY;
      return n;
   endfunction

   // least non-negative active cost along a row or a column, skipping one index
   function automatic int line_min(bit along_row, int k, int skip, int n);
      bit have;
      int m, v;
      have = 0;
      m = 0;
      for (int j = 0; j < n; j++) begin
         if (j == skip) continue;
         if (along_row) begin
            if (col_gone[j]) continue;
            v = mat[k][j];
         end else begin
            if (row_gone[j]) continue;
            v = mat[j][k];
         end
         if (v >= 0 && (!have || v < m)) begin
            m = v;
            have = 1;
         end
      end
      return m;
   endfunction

   function automatic outcome_type reduce_matrix(int n);
      outcome_type o;
      longint s;
      int m;
      bit allf;
      s = 0;
      allf = 1;
      for (int r = 0; r < n; r++) begin
         if (row_gone[r]) continue;
         m = line_min(1, r, -1, n);
         s += m;
         for (int c = 0; c < n; c++)
            if (!col_gone[c] && mat[r][c] > 0) mat[r][c] -= m;
      end
      for (int c = 0; c < n; c++) begin
         if (col_gone[c]) continue;
         m = line_min(0, c, -1, n);
         s += m;
         for (int r = 0; r < n; r++)
            if (!row_gone[r] && mat[r][c] > 0) mat[r][c] -= m;
      end
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (!row_gone[r] && !col_gone[c] && mat[r][c] != -1) allf = 0;
      if (s > SUM_MAX) s = SUM_MAX;
      o = '{1'b0, s[SUM_W-1:0], allf, 5'd0, 5'd0, '0, 1'b0};
      return o;
   endfunction

   function automatic outcome_type best_zero(int n);
      outcome_type o;
      longint best, p;
      bit found;
      int br, bc;
      found = 0;
      best = 0;
      br = 0;
      bc = 0;
      for (int r = 0; r < n; r++) begin
         if (row_gone[r]) continue;
         for (int c = 0; c < n; c++) begin
            if (col_gone[c] || mat[r][c] != 0) continue;
            p = line_min(1, r, c, n) + line_min(0, c, r, n);
            if (!found || p > best) begin
               best = p;
               br = r;
               bc = c;
               found = 1;
            end
         end
      end
      if (best > PEN_MAX) best = PEN_MAX;
      o = '{1'b1, '0, 1'b0, br[4:0], bc[4:0], best[PEN_W-1:0], found};
      return o;
   endfunction

   function automatic void apply_request(cell_req_type q);
      int n, r, c;
      bit in_rng;
      n = cities_in_use();
      r = q.row;
      c = q.col;
      in_rng = (r < n) && (c < n);
      case (q.op)
         OP_LOAD: if (in_rng) begin
            mat[r][c] = q.cost[16] ? -1 : int'(q.cost[15:0]);
            row_gone[r] = 0;
            col_gone[c] = 0;
         end
         OP_FORBID: if (in_rng && !row_gone[r] && !col_gone[c]) mat[r][c] = -1;
         OP_DELETE: if (in_rng) begin
            if (!row_gone[c] && !col_gone[r]) mat[c][r] = -1;
            row_gone[r] = 1;
            col_gone[c] = 1;
         end
         OP_REDUCE: expected_outcomes.insert(expected_outcomes.size(), reduce_matrix(n));
         OP_EVAL: expected_outcomes.insert(expected_outcomes.size(), best_zero(n));
         default: ;
      endcase
   endfunction

   // accept side: predict on request, track configuration, check responses
   always @(posedge clock) begin
      outcome_type e;
      cycles <= cycles + 1;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) size_reg = csr_size_in_use;
         if (req_valid && req_ready)
            apply_request('{req_opcode, req_row, req_col, req_cost});
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
            end else begin
               e = expected_outcomes.pop_front();
               if (e.kind != rsp_result_kind || e.sum != rsp_reduction_sum ||
                   e.all_forb != rsp_all_forbidden || e.brow != rsp_branch_row ||
                   e.bcol != rsp_branch_col || e.pen != rsp_branch_penalty ||
                   e.zfound != rsp_zero_found) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch cycle %0d exp k%0d s%0d af%0d r%0d c%0d p%0d z%0d act k%0d s%0d af%0d r%0d c%0d p%0d z%0d",
                        cycles, e.kind, e.sum, e.all_forb, e.brow, e.bcol, e.pen,
                        e.zfound, rsp_result_kind, rsp_reduction_sum,
                        rsp_all_forbidden, rsp_branch_row, rsp_branch_col,
                        rsp_branch_penalty, rsp_zero_found);
               end
            end
         end
      end
      if (cycles > CYCLE_CAP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // request driver: hold the request until taken, then advance or idle
   always @(negedge clock) begin
      cell_req_type q;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
            q = pending_reqs.pop_front();
            req_valid  <= 1'b1;
            req_opcode <= q.op;
            req_row    <= q.row;
            req_col    <= q.col;
            req_cost   <= q.cost;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: random back-pressure plus one long hold-off
   always @(negedge clock) begin
      if (stall_now && !stall_started) begin
         stall_started <= 1'b1;
         hold_left <= HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 30);
      end
   end

   function automatic void push_req(opcode_type op, int r, int c, int cost);
      logic [PORT_COST_W-1:0] cv;
      cell_req_type item;
      cv = PORT_COST_W'(cost);
      item = '{op, r[4:0], c[4:0], cv};
      pending_reqs.insert(pending_reqs.size(), item);
      if (op == OP_LOAD && r < gen_n && c < gen_n) loaded[r][c] = 1;
   endfunction

   function automatic int random_cost();
      case ($urandom_range(9))
         0: return 0;
         1: return -1;
         2: return 65535;
         3: return -int'($urandom_range(65536, 1));
         4: return $urandom_range(65535);
         default: return $urandom_range(12);
      endcase
   endfunction

   // load every in-use cell not yet written, so no scan reads an unknown cell
   function automatic void fill_unloaded();
      for (int r = 0; r < gen_n; r++)
         for (int c = 0; c < gen_n; c++)
            if (!loaded[r][c]) push_req(OP_LOAD, r, c, random_cost());
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(int sz);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_size_in_use <= sz[SIZE_W-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
      gen_n = (sz == 0) ? 1 : (sz > NCITY ? NCITY : sz);
   endtask

   task automatic random_phase(int sz, int count);
      int r, c;
      write_size(sz);
      fill_unloaded();
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(gen_n - 1);
         c = $urandom_range(gen_n - 1);
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: push_req(OP_LOAD, r, c, random_cost());
            6, 7: push_req(OP_FORBID, r, c, $urandom_range(65535));
            8, 9, 10: push_req(OP_DELETE, r, c, random_cost());
            11, 12, 13: push_req(OP_REDUCE, r, c, random_cost());
            14, 15, 16: push_req(OP_EVAL, r, c, random_cost());
            17: push_req(opcode_type'($urandom_range(7, 5)), $urandom_range(31),
                         $urandom_range(31), random_cost());
            default: push_req(opcode_type'($urandom_range(2)), $urandom_range(31),
                              $urandom_range(31), random_cost());
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part on a 4-city matrix
      write_size(4);
      fill_unloaded();
      push_req(OP_LOAD, 0, 1, 65535);
      push_req(OP_LOAD, 1, 0, -1);
      push_req(OP_LOAD, 2, 3, -5);
      push_req(OP_LOAD, 3, 3, 0);
      push_req(OP_FORBID, 0, 2, 0);
      push_req(opcode_type'(5), 31, 31, -1);
      push_req(opcode_type'(6), 0, 0, 0);
      push_req(opcode_type'(7), 21, 10, 65535);
      push_req(OP_LOAD, 9, 0, 7);
      push_req(OP_DELETE, 0, 30, 0);
      push_req(OP_REDUCE, 0, 0, 0);
      push_req(OP_EVAL, 0, 0, 0);
      push_req(OP_DELETE, 1, 2, 0);
      push_req(OP_DELETE, 1, 2, 0);
      push_req(OP_FORBID, 1, 0, 0);
      push_req(OP_REDUCE, 0, 0, 0);
      push_req(OP_EVAL, 0, 0, 0);
      push_req(OP_LOAD, 1, 3, 4);
      push_req(OP_EVAL, 0, 0, 0);
      for (int i = 0; i < 4; i++) push_req(OP_DELETE, i, i, 0);
      push_req(OP_REDUCE, 0, 0, 0);
      push_req(OP_EVAL, 0, 0, 0);

      // long response hold-off while requests keep coming
      for (int i = 0; i < 6; i++) begin
         push_req(OP_LOAD, i % 4, (i + 1) % 4, $urandom_range(9));
         push_req(OP_REDUCE, 0, 0, 0);
         push_req(OP_EVAL, 0, 0, 0);
      end
      stall_now = 1'b1;

      random_phase(1, 20);
      random_phase(0, 15);

      // full-size matrix: drop every line beyond the first four, then scan
      write_size(32);
      for (int i = 4; i < NCITY; i++) push_req(OP_DELETE, i, i, 0);
      push_req(OP_REDUCE, 0, 0, 0);
      push_req(OP_EVAL, 0, 0, 0);
      push_req(OP_FORBID, 31, 31, 0);
      push_req(OP_LOAD, 2, 1, 3);
      push_req(OP_REDUCE, 0, 0, 0);
      push_req(OP_EVAL, 0, 0, 0);

      // size beyond the matrix acts as the full matrix
      write_size(63);
      push_req(OP_DELETE, 31, 30, 0);
      push_req(OP_FORBID, 3, 2, 0);
      push_req(OP_REDUCE, 0, 0, 0);
      push_req(OP_EVAL, 0, 0, 0);

      calm = 1'b1;
      random_phase(3, 40);
      calm = 1'b0;
      random_phase(2, 25);
      random_phase(6, 45);
      random_phase(5, 40);

      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
